// ===== rtl/core/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector package
// Shared widths, microcode word layout, step program and status records.
// ----------------------------------------------------------------------------
package rpd_pkg;

	// Default number of bytes kept for one string.
	localparam int unsigned MAX_LEN_DEFAULT = 1024;

	// Fixed widths of the byte and of the result fields.
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned PERIOD_W = 11;
	localparam int unsigned BORDER_W = 10;
	localparam int unsigned LEN_W    = 11;

	// Step counter of the sequencer.
	localparam int unsigned STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// Datapath operations, one per control word.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TAKE,
		OP_CLASSIFY,
		OP_MATCH,
		OP_FALLBACK,
		OP_COMMIT,
		OP_DIV_START,
		OP_EMIT
	} op_t;

	// Jump conditions; when the condition fails the step counter moves on by one.
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_FULL,
		JC_RESOLVED,
		JC_NOT_LAST,
		JC_DIV_BUSY
	} jump_cond_t;

	typedef struct packed {
		logic       wait_in;
		logic       wait_out;
		op_t        op;
		jump_cond_t cond;
		step_t      target;
	} ctrl_word_t;

	// Flags from the datapath that the jump conditions test.
	typedef struct packed {
		logic full;
		logic resolved;
		logic not_last;
		logic div_busy;
	} status_t;

	typedef struct packed {
		logic                repeated;
		logic [PERIOD_W-1:0] period;
		logic [BORDER_W-1:0] border_len;
		logic [LEN_W-1:0]    str_len;
		logic                too_long;
	} result_t;

	// Step addresses of the program.
	localparam step_t STEP_FETCH     = 4'd0;
	localparam step_t STEP_CLASSIFY  = 4'd1;
	localparam step_t STEP_MATCH     = 4'd2;
	localparam step_t STEP_FALLBACK  = 4'd3;
	localparam step_t STEP_COMMIT    = 4'd4;
	localparam step_t STEP_END_CHECK = 4'd5;
	localparam step_t STEP_DIV_START = 4'd6;
	localparam step_t STEP_DIV_WAIT  = 4'd7;
	localparam step_t STEP_EMIT      = 4'd8;

	function automatic ctrl_word_t make_word(logic wi, logic wo, op_t op,
			jump_cond_t cond, step_t target);
		ctrl_word_t w;
		w.wait_in  = wi;
		w.wait_out = wo;
		w.op       = op;
		w.cond     = cond;
		w.target   = target;
		return w;
	endfunction

	// The control program, one word per step.
	function automatic ctrl_word_t rom_word(step_t step);
		ctrl_word_t w;
		case (step)
			STEP_FETCH:     w = make_word(1'b1, 1'b0, OP_TAKE, JC_NEXT, STEP_FETCH);
			STEP_CLASSIFY:  w = make_word(1'b0, 1'b0, OP_CLASSIFY, JC_FULL, STEP_END_CHECK);
			STEP_MATCH:     w = make_word(1'b0, 1'b0, OP_MATCH, JC_RESOLVED, STEP_COMMIT);
			STEP_FALLBACK:  w = make_word(1'b0, 1'b0, OP_FALLBACK, JC_ALWAYS, STEP_MATCH);
			STEP_COMMIT:    w = make_word(1'b0, 1'b0, OP_COMMIT, JC_NOT_LAST, STEP_FETCH);
			STEP_END_CHECK: w = make_word(1'b0, 1'b0, OP_NONE, JC_NOT_LAST, STEP_FETCH);
			STEP_DIV_START: w = make_word(1'b0, 1'b0, OP_DIV_START, JC_NEXT, STEP_FETCH);
			STEP_DIV_WAIT:  w = make_word(1'b0, 1'b0, OP_NONE, JC_DIV_BUSY, STEP_DIV_WAIT);
			STEP_EMIT:      w = make_word(1'b0, 1'b1, OP_EMIT, JC_ALWAYS, STEP_FETCH);
			default:        w = make_word(1'b0, 1'b0, OP_NONE, JC_ALWAYS, STEP_FETCH);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/rpd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector remainder unit
// Restoring remainder of dividend by divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpd_mod_unit #(
	parameter int unsigned WIDTH = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             busy,
	output logic [WIDTH-1:0] remainder
);
	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] shift_q;
	logic [WIDTH-1:0] div_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;

	assign trial = {rem_q, shift_q[WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			div_q   <= divisor;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[WIDTH-2:0], 1'b0};
			// The partial remainder stays below the divisor, so it fits WIDTH bits.
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[WIDTH-1:0];
			end else begin
				rem_q <= trial[WIDTH-1:0];
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

endmodule

// ===== rtl/core/rpd_datapath.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector datapath
// Byte and border stores, match length, count and the final result logic.
// ----------------------------------------------------------------------------
module rpd_datapath #(
	parameter int unsigned MAX_LEN = rpd_pkg::MAX_LEN_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  rpd_pkg::ctrl_word_t       ctrl,
	input  logic [rpd_pkg::CHAR_W-1:0] char_in,
	input  logic                      last,
	output rpd_pkg::status_t          status,
	output rpd_pkg::result_t          result
);
	import rpd_pkg::*;

	localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);

	logic [CHAR_W-1:0] char_mem [MAX_LEN];
	logic [ADDR_W-1:0] border_mem [MAX_LEN];

	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [ADDR_W-1:0] match_len_q;
	logic [CNT_W-1:0]  count_q;
	logic              overflow_q;
	logic [CHAR_W-1:0] char_rd_q;
	logic [ADDR_W-1:0] border_rd_q;

	logic              op_fire;
	logic              is_first;
	logic              hit;
	logic              resolved;
	logic              char_rd_en;
	logic [ADDR_W-1:0] char_rd_addr;
	logic              border_rd_en;
	logic              commit;
	logic [CNT_W-1:0]  period_full;
	logic [CNT_W-1:0]  border_ext;
	logic [CNT_W-1:0]  remainder;
	logic              div_busy;

	assign op_fire  = fire;
	assign is_first = (count_q == '0);
	assign hit      = (char_q == char_rd_q);
	assign resolved = is_first || hit || (match_len_q == '0);

	assign char_rd_en   = op_fire && ((ctrl.op == OP_TAKE) || (ctrl.op == OP_FALLBACK));
	assign char_rd_addr = (ctrl.op == OP_FALLBACK) ? border_rd_q : match_len_q;
	assign border_rd_en = op_fire && (ctrl.op == OP_MATCH) && !resolved;
	assign commit       = op_fire && (ctrl.op == OP_COMMIT);

	always_ff @(posedge clk) begin
		if (char_rd_en) begin
			char_rd_q <= char_mem[char_rd_addr];
		end
		if (border_rd_en) begin
			border_rd_q <= border_mem[match_len_q - 1'b1];
		end
		if (commit) begin
			char_mem[count_q[ADDR_W-1:0]]   <= char_q;
			border_mem[count_q[ADDR_W-1:0]] <= match_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (op_fire && (ctrl.op == OP_TAKE)) begin
			char_q <= char_in;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_len_q <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
		end else if (op_fire) begin
			case (ctrl.op)
				OP_CLASSIFY: begin
					if (status.full) begin
						overflow_q <= 1'b1;
					end
				end
				OP_MATCH: begin
					if (!is_first && hit) begin
						match_len_q <= match_len_q + 1'b1;
					end
				end
				OP_FALLBACK: begin
					match_len_q <= border_rd_q;
				end
				OP_COMMIT: begin
					count_q <= count_q + 1'b1;
				end
				OP_EMIT: begin
					match_len_q <= '0;
					count_q     <= '0;
					overflow_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign border_ext  = CNT_W'(match_len_q);
	assign period_full = count_q - border_ext;

	rpd_mod_unit #(
		.WIDTH(CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (op_fire && (ctrl.op == OP_DIV_START)),
		.dividend  (count_q),
		.divisor   (period_full),
		.busy      (div_busy),
		.remainder (remainder)
	);

	assign status.full     = (count_q == CNT_W'(MAX_LEN));
	assign status.resolved = resolved;
	assign status.not_last = !last_q;
	assign status.div_busy = div_busy;

	logic [CNT_W+PERIOD_W-1:0] period_wide;
	logic [CNT_W+BORDER_W-1:0] border_wide;
	logic [CNT_W+LEN_W-1:0]    len_wide;

	assign period_wide = {{PERIOD_W{1'b0}}, period_full};
	assign border_wide = {{BORDER_W{1'b0}}, border_ext};
	assign len_wide    = {{LEN_W{1'b0}}, count_q};

	assign result.repeated   = (match_len_q != '0) && (remainder == '0);
	assign result.period     = period_wide[PERIOD_W-1:0];
	assign result.border_len = border_wide[BORDER_W-1:0];
	assign result.str_len    = len_wide[LEN_W-1:0];
	assign result.too_long   = overflow_q;

endmodule

// ===== rtl/core/rpd_sequencer.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector sequencer
// Step counter over the control program with conditional jumps and stalls.
// ----------------------------------------------------------------------------
module rpd_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_blocked,
	input  rpd_pkg::status_t    status,
	output rpd_pkg::ctrl_word_t ctrl,
	output logic                fire
);
	import rpd_pkg::*;

	step_t step_q;
	logic  take_jump;

	assign ctrl = rom_word(step_q);
	// A step waits on the input request or on a full output slot.
	assign fire = !(ctrl.wait_in && !in_valid) && !(ctrl.wait_out && out_blocked);

	always_comb begin
		case (ctrl.cond)
			JC_NEXT:     take_jump = 1'b0;
			JC_ALWAYS:   take_jump = 1'b1;
			JC_FULL:     take_jump = status.full;
			JC_RESOLVED: take_jump = status.resolved;
			JC_NOT_LAST: take_jump = status.not_last;
			JC_DIV_BUSY: take_jump = status.div_busy;
			default:     take_jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else if (fire) begin
			step_q <= take_jump ? ctrl.target : step_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/repeated_pattern_detector.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector
// Online KMP prefix table over a byte string with a whole-repetition test.
// ----------------------------------------------------------------------------
// Bytes arrive one per input request, the final one marked by last. For each
// kept byte the block finds the longest proper border of the prefix so far,
// the way the KMP failure table is built, and stores the byte and that border.
// A kept byte passes the fetch, classify, match and commit steps, with a
// fallback step for each fallback of the border search; every fallback reads
// the border store and then the byte store through their single registered
// read ports, and over a string the fallbacks average under one per byte. A
// byte that arrives once MAX_LEN bytes are kept is dropped and marks the string
// as too long. After the final byte, a bit-serial remainder unit checks whether
// the period divides the length. The result then sits in an output register
// until taken, and the next string may already stream in meanwhile. The stores
// need no clearing after reset: a string only reads entries it wrote itself.
module repeated_pattern_detector #(
	parameter int unsigned MAX_LEN = rpd_pkg::MAX_LEN_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rpd_pkg::CHAR_W-1:0]   char_in,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         repeated,
	output logic [rpd_pkg::PERIOD_W-1:0] period,
	output logic [rpd_pkg::BORDER_W-1:0] border_len,
	output logic [rpd_pkg::LEN_W-1:0]    str_len,
	output logic                         too_long
);
	import rpd_pkg::*;

	ctrl_word_t ctrl;
	status_t    status;
	result_t    result;
	result_t    result_q;
	logic       fire;
	logic       out_valid_q;
	logic       out_blocked;
	logic       emit;

	// The emit step stalls only while an earlier result has not been taken.
	assign out_blocked = out_valid_q && !out_ready;
	assign emit        = fire && (ctrl.op == OP_EMIT);

	rpd_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.out_blocked (out_blocked),
		.status      (status),
		.ctrl        (ctrl),
		.fire        (fire)
	);

	rpd_datapath #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.ctrl    (ctrl),
		.char_in (char_in),
		.last    (last),
		.status  (status),
		.result  (result)
	);

	// Output slot: loaded by the emit step, freed by the downstream request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result;
		end
	end

	// The fetch step is the only one that takes an input request.
	assign in_ready   = ctrl.wait_in;
	assign out_valid  = out_valid_q;
	assign repeated   = result_q.repeated;
	assign period     = result_q.period;
	assign border_len = result_q.border_len;
	assign str_len    = result_q.str_len;
	assign too_long   = result_q.too_long;

endmodule

// ===== rtl/core/rpd_checker.sv =====
// ----------------------------------------------------------------------------
// Repeated pattern detector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         repeated,
	input logic [rpd_pkg::PERIOD_W-1:0] period,
	input logic [rpd_pkg::BORDER_W-1:0] border_len,
	input logic [rpd_pkg::LEN_W-1:0]    str_len,
	input logic                         too_long
);
	import rpd_pkg::*;

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({repeated, period, border_len, str_len, too_long}))
		else $error("result changed while stalled");

	// Period and border always add up to the length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (period + LEN_W'(border_len)) == str_len)
		else $error("period plus border differs from length");

	// A repetition needs a non-empty border.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeated |-> border_len != '0)
		else $error("repetition flagged with empty border");

	// Every result describes at least one byte and has a non-zero period.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (str_len != '0) && (period != '0))
		else $error("empty length or period in result");

endmodule

bind repeated_pattern_detector rpd_checker u_rpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.repeated   (repeated),
	.period     (period),
	.border_len (border_len),
	.str_len    (str_len),
	.too_long   (too_long)
);
